// ----- rtl/dcls_pkg.sv -----
package dcls_pkg;

  typedef enum logic [2:0] {
    PH_INIT       = 3'd0,
    PH_SELECTING  = 3'd1,
    PH_REQUESTING = 3'd2,
    PH_BOUND      = 3'd3,
    PH_REBINDING  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_REPLY = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SEND_NONE     = 2'd0,
    SEND_DISCOVER = 2'd1,
    SEND_REQUEST  = 2'd2,
    SEND_RENEW    = 2'd3
  } send_e;

  typedef enum logic [1:0] {
    BC_KEEP    = 2'd0,
    BC_ENABLE  = 2'd1,
    BC_DISABLE = 2'd2
  } bcast_e;

  localparam logic [7:0]  MSG_OFFER       = 8'd2;
  localparam logic [7:0]  MSG_ACK         = 8'd5;
  localparam logic [7:0]  MSG_NAK         = 8'd6;
  localparam logic [7:0]  BOOTP_REPLY     = 8'd2;
  localparam logic [7:0]  SERVER_PORT_LOW = 8'd67;
  localparam logic [6:0]  FIRST_RETRY     = 7'd4;
  localparam logic [6:0]  RETRY_LIMIT     = 7'd32;
  localparam logic [6:0]  RENEW_TRIES     = 7'd3;
  localparam logic [31:0] LEASE_INFINITE  = 32'hffff_ffff;
  // renew at half the lease, retry at an eighth
  localparam int unsigned RENEW_SHIFT = 1;
  localparam int unsigned RETRY_SHIFT = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic        link_up;
    logic [7:0]  reply_op;
    logic [7:0]  reply_src_port_low;
    logic [31:0] reply_xid;
    logic [7:0]  msg_type;
    logic        lease_present;
    logic [31:0] lease_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0] client_state;
    logic [7:0] xid_byte;
    logic [1:0] send_kind;
    logic [1:0] broadcast_ctl;
    logic       got_address;
    logic       reply_consumed;
  } out_item_t;

endpackage

// ----- rtl/dcls_if.sv -----
interface dcls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        link_up;
  logic [7:0]  reply_op;
  logic [7:0]  reply_src_port_low;
  logic [31:0] reply_xid;
  logic [7:0]  msg_type;
  logic        lease_present;
  logic [31:0] lease_seconds;

  modport source (
    output valid, action, link_up, reply_op, reply_src_port_low, reply_xid,
           msg_type, lease_present, lease_seconds,
    input  ready
  );
  modport sink (
    input  valid, action, link_up, reply_op, reply_src_port_low, reply_xid,
           msg_type, lease_present, lease_seconds,
    output ready
  );
endinterface

interface dcls_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] client_state;
  logic [7:0] xid_byte;
  logic [1:0] send_kind;
  logic [1:0] broadcast_ctl;
  logic       got_address;
  logic       reply_consumed;

  modport source (
    output valid, client_state, xid_byte, send_kind, broadcast_ctl, got_address,
           reply_consumed,
    input  ready
  );
  modport sink (
    input  valid, client_state, xid_byte, send_kind, broadcast_ctl, got_address,
           reply_consumed,
    output ready
  );
endinterface

// ----- rtl/dcls_in_stage.sv -----
module dcls_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  dcls_in_if.sink           req_i,
  input  logic              take_i,
  output logic              valid_o,
  output dcls_pkg::in_item_t item_o
);

  logic               valid_q;
  dcls_pkg::in_item_t item_q;
  logic               load;

  assign req_i.ready = !valid_q || take_i;
  assign load        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.action             <= req_i.action;
      item_q.link_up            <= req_i.link_up;
      item_q.reply_op           <= req_i.reply_op;
      item_q.reply_src_port_low <= req_i.reply_src_port_low;
      item_q.reply_xid          <= req_i.reply_xid;
      item_q.msg_type           <= req_i.msg_type;
      item_q.lease_present      <= req_i.lease_present;
      item_q.lease_seconds      <= req_i.lease_seconds;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/dcls_engine.sv -----
module dcls_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  dcls_pkg::in_item_t  item_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output dcls_pkg::out_item_t result_o
);

  dcls_pkg::phase_e phase_q, phase_d;
  logic [7:0]       xid_q, xid_d;
  logic [6:0]       retry_q, retry_d;
  logic [31:0]      count_q, count_d;
  logic [31:0]      lease_q, lease_d;

  logic        is_poll, is_reply, is_tick, renew_side, match;
  logic [6:0]  retry_inc, retry_dbl;
  logic [31:0] lease_new, half_old, half_new, eighth;

  assign is_tick  = item_i.action == dcls_pkg::ACT_TICK;
  assign is_poll  = item_i.action == dcls_pkg::ACT_POLL;
  assign is_reply = item_i.action == dcls_pkg::ACT_REPLY;
  // unused phase codes would behave as rebinding
  assign renew_side = phase_q >= dcls_pkg::PH_BOUND;

  assign match = (item_i.reply_op == dcls_pkg::BOOTP_REPLY)
              && (item_i.reply_src_port_low == dcls_pkg::SERVER_PORT_LOW)
              && (item_i.reply_xid[7:0]   == xid_q)
              && (item_i.reply_xid[15:8]  == xid_q)
              && (item_i.reply_xid[23:16] == xid_q)
              && (item_i.reply_xid[31:24] == xid_q);

  assign retry_inc = 7'(retry_q + 7'd1);
  assign retry_dbl = {retry_q[5:0], 1'b0};
  assign lease_new = item_i.lease_present ? item_i.lease_seconds : lease_q;
  assign half_old  = lease_q >> dcls_pkg::RENEW_SHIFT;
  assign half_new  = lease_new >> dcls_pkg::RENEW_SHIFT;
  assign eighth    = lease_q >> dcls_pkg::RETRY_SHIFT;

  // next state
  always_comb begin
    phase_d = phase_q;
    xid_d   = xid_q;
    retry_d = retry_q;
    count_d = count_q;
    lease_d = lease_q;
    if (cfg_we_i) begin
      xid_d   = cfg_wdata_i;
      phase_d = dcls_pkg::PH_INIT;
    end else if (step_i) begin
      if (is_tick) begin
        if (count_q != '0 && count_q != dcls_pkg::LEASE_INFINITE) begin
          count_d = count_q - 32'd1;
        end
      end else if (is_poll || is_reply) begin
        if (renew_side) begin
          if (is_poll && count_q == '0) begin
            if (item_i.link_up) begin
              xid_d   = 8'(xid_q + 8'd1);
              count_d = eighth;
              retry_d = retry_inc;
              phase_d = (eighth == '0 || retry_inc > dcls_pkg::RENEW_TRIES)
                        ? dcls_pkg::PH_INIT : dcls_pkg::PH_REBINDING;
            end
          end else if (is_reply && match) begin
            if (item_i.msg_type == dcls_pkg::MSG_ACK) begin
              retry_d = '0;
              lease_d = lease_new;
              count_d = half_new;
              phase_d = (half_new == '0) ? dcls_pkg::PH_INIT : dcls_pkg::PH_BOUND;
            end else if (item_i.msg_type == dcls_pkg::MSG_NAK) begin
              phase_d = dcls_pkg::PH_INIT;
            end
          end
        end else if (item_i.link_up) begin
          if (is_poll) begin
            if (phase_q == dcls_pkg::PH_INIT) begin
              phase_d = dcls_pkg::PH_SELECTING;
              retry_d = dcls_pkg::FIRST_RETRY;
              count_d = 32'(dcls_pkg::FIRST_RETRY);
            end else if (count_q == '0) begin
              xid_d   = 8'(xid_q + 8'd1);
              retry_d = retry_dbl;
              if (retry_dbl > dcls_pkg::RETRY_LIMIT) begin
                phase_d = dcls_pkg::PH_INIT;
              end else begin
                count_d = 32'(retry_dbl);
              end
            end
          end else if (match) begin
            if (item_i.msg_type == dcls_pkg::MSG_OFFER) begin
              phase_d = dcls_pkg::PH_REQUESTING;
              retry_d = dcls_pkg::FIRST_RETRY;
              count_d = 32'(dcls_pkg::FIRST_RETRY);
              lease_d = lease_new;
            end else if (item_i.msg_type == dcls_pkg::MSG_ACK) begin
              retry_d = '0;
              count_d = half_old;
              phase_d = (half_old == '0) ? dcls_pkg::PH_INIT : dcls_pkg::PH_BOUND;
            end else if (item_i.msg_type == dcls_pkg::MSG_NAK) begin
              phase_d = dcls_pkg::PH_INIT;
            end
          end
        end
      end
    end
  end

  // outputs
  always_comb begin
    result_o.client_state   = phase_d;
    result_o.xid_byte       = xid_d;
    result_o.send_kind      = dcls_pkg::SEND_NONE;
    result_o.broadcast_ctl  = dcls_pkg::BC_KEEP;
    result_o.got_address    = 1'b0;
    result_o.reply_consumed = 1'b0;
    if (is_poll || is_reply) begin
      if (renew_side) begin
        if (is_poll && count_q == '0) begin
          if (item_i.link_up) begin
            result_o.send_kind      = dcls_pkg::SEND_RENEW;
            result_o.broadcast_ctl  = dcls_pkg::BC_ENABLE;
            result_o.reply_consumed = 1'b1;
          end
        end else if (is_reply && match) begin
          result_o.reply_consumed = 1'b1;
          if (item_i.msg_type == dcls_pkg::MSG_ACK) begin
            result_o.broadcast_ctl = dcls_pkg::BC_DISABLE;
          end
        end
      end else if (item_i.link_up) begin
        if (is_poll) begin
          if (phase_q == dcls_pkg::PH_INIT) begin
            result_o.send_kind     = dcls_pkg::SEND_DISCOVER;
            result_o.broadcast_ctl = dcls_pkg::BC_ENABLE;
          end else if (count_q == '0 && retry_dbl <= dcls_pkg::RETRY_LIMIT) begin
            result_o.send_kind = (phase_q == dcls_pkg::PH_SELECTING)
                                 ? dcls_pkg::SEND_DISCOVER : dcls_pkg::SEND_REQUEST;
          end
        end else if (match) begin
          if (item_i.msg_type == dcls_pkg::MSG_OFFER) begin
            result_o.send_kind = dcls_pkg::SEND_REQUEST;
          end else if (item_i.msg_type == dcls_pkg::MSG_ACK) begin
            result_o.broadcast_ctl = dcls_pkg::BC_DISABLE;
            result_o.got_address   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dcls_pkg::PH_INIT;
      xid_q   <= '0;
      retry_q <= '0;
      count_q <= '0;
      lease_q <= dcls_pkg::LEASE_INFINITE;
    end else begin
      phase_q <= phase_d;
      xid_q   <= xid_d;
      retry_q <= retry_d;
      count_q <= count_d;
      lease_q <= lease_d;
    end
  end

endmodule

// ----- rtl/dcls_out_stage.sv -----
module dcls_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  dcls_pkg::out_item_t item_i,
  output logic                ready_o,
  dcls_out_if.source          rsp_o
);

  logic                valid_q;
  dcls_pkg::out_item_t item_q;

  assign ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign rsp_o.valid          = valid_q;
  assign rsp_o.client_state   = item_q.client_state;
  assign rsp_o.xid_byte       = item_q.xid_byte;
  assign rsp_o.send_kind      = item_q.send_kind;
  assign rsp_o.broadcast_ctl  = item_q.broadcast_ctl;
  assign rsp_o.got_address    = item_q.got_address;
  assign rsp_o.reply_consumed = item_q.reply_consumed;

endmodule

// ----- rtl/dhcp_client_lease_sequencer_unit.sv -----
// DHCP client lease sequencer.
// req_i carries one event per transaction: a one-second tick, a poll, or a
// received reply with its header fields and options already extracted.
// rsp_o returns exactly one result per event: client state, transaction id,
// which message to send, broadcast control and the got-address/consumed flags.
// The event is registered on entry, then the state update and result are
// formed combinationally into the output register: rsp_o.valid rises once the
// result is loaded there from the input register, and one event per cycle is
// sustained while rsp_o.ready stays high, since the state registers update in
// the same cycle as the output register is loaded.
// If the receiver holds rsp_o.ready low, the result waits in the output
// register and one further event is held in the input register; req_i.ready
// then drops until the result is taken.
// Reset empties both registers and sets state to init, id 0, retry and
// countdown 0, lease infinite. A cfg_we_i write loads the transaction id and
// returns the client to init; write it only while no events are in flight.
module dhcp_client_lease_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  dcls_in_if.sink    req_i,
  dcls_out_if.source rsp_o
);

  logic                in_valid, out_ready, step;
  dcls_pkg::in_item_t  item;
  dcls_pkg::out_item_t result;

  assign step = in_valid && out_ready;

  dcls_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (out_ready),
    .valid_o (in_valid),
    .item_o  (item)
  );

  dcls_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result)
  );

  dcls_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .item_i  (result),
    .ready_o (out_ready),
    .rsp_o   (rsp_o)
  );

endmodule
